// ----- hdl/nfrd_pkg.sv -----
// Package for the nearest fingerprint RSSI distance block.
// It holds the command codes, the beat types and the control state type.
// It has no dependencies.
`timescale 1ns / 1ps

package nfrd_pkg;

   localparam int MAX_ENTRIES_DEF = 256;
   localparam int NUM_BEACONS_DEF = 8;

   localparam logic [1:0] CMD_POSE     = 2'd0;
   localparam logic [1:0] CMD_REF_RSSI = 2'd1;
   localparam logic [1:0] CMD_OBS_RSSI = 2'd2;
   localparam logic [1:0] CMD_QUERY    = 2'd3;

   localparam logic [15:0] ALL_MISSING_DIST = 16'd160;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [7:0]         entry_index;
      logic [2:0]         beacon_index;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic [12:0]        orientation;
      logic signed [11:0] rssi_value;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] radio_distance;
      logic [7:0]  nearest_index;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic [12:0]        orientation;
   } pose_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RADIO,
      ST_PREP,
      ST_SQ,
      ST_CMP,
      ST_DONE
   } state_type;

endpackage

// ----- hdl/nfrd_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// It has no dependencies.
`timescale 1ns / 1ps

module nfrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/nearest_fingerprint_rssi_distance_top.sv -----
// Top level of the nearest fingerprint RSSI distance block.
// It depends on nfrd_pkg and nfrd_ram.
`timescale 1ns / 1ps

// Usage:
// A command beat is taken on req_data at a rising edge where start is high and busy
// is low. Pose, fingerprint RSSI and observed RSSI writes leave busy low, so writes
// can follow back to back. A query raises busy until its result has been shown.
// A query scans the pose memory one entry per cycle for entries_in_use entries
// (at least one, at most MAX_ENTRIES), then reads the selected fingerprint's
// readings one beacon per cycle, then, if any reading is present, finds the
// square root one bit at a time over 16 bits, each bit in the ST_SQ then ST_CMP
// states; with no reading present it gives ALL_MISSING_DIST.
// The result beat is on rsp_data for one cycle with rsp_valid high, and busy drops
// in the next cycle. The receiver cannot stall it.
// The csr channel writes entries_in_use and is ready whenever busy is low.
// Reset returns the control to idle and entries_in_use to one; memory contents are
// not cleared and must be written before they are used.
module nearest_fingerprint_rssi_distance_top
   import nfrd_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int NUM_BEACONS = NUM_BEACONS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [8:0]      csr_data
);

   localparam int EW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int BW     = (NUM_BEACONS > 1) ? $clog2(NUM_BEACONS) : 1;
   localparam int CNT_W  = $clog2(NUM_BEACONS + 1);
   localparam int DIST_W = 51;
   localparam int SQ_W   = 26;
   localparam int TOT_W  = SQ_W + CNT_W;
   localparam int NUM_W  = TOT_W + CNT_W;
   localparam int PRD_W  = 32 + CNT_W;
   localparam int CMP_W  = (NUM_W > PRD_W) ? NUM_W : PRD_W;
   localparam int POSE_W = $bits(pose_type);

   state_type state_ff, state_in;

   logic [8:0]  csr_ff;
   logic        accept;
   logic        pose_we, ref_we, obs_we;

   logic [EW-1:0] last_ff;
   logic [EW-1:0] scan_ff;
   logic          scan_done_ff;
   logic          scan_rd;
   logic          s1_vld_ff, s2_vld_ff;
   logic [EW-1:0] s1_idx_ff, s2_idx_ff;
   logic [2*25-1:0] sqx_ff, sqy_ff;
   logic [12:0]   ang_ff;
   logic          first_ff;
   logic [DIST_W-1:0] best_d_ff;
   logic [12:0]   best_a_ff;
   logic [EW-1:0] best_ff;
   logic [DIST_W-1:0] cur_d;

   logic signed [23:0] qx_ff, qy_ff;
   logic [12:0]        qori_ff;

   pose_type      pose_wr, pose_rd;
   logic [POSE_W-1:0] pose_rd_bits;
   logic signed [24:0] dx, dy;
   logic [24:0]   adx, ady;
   logic [12:0]   adiff;

   logic [BW-1:0] rb_ff;
   logic          rad_done_ff;
   logic          rad_rd;
   logic          r1_vld_ff, r2_vld_ff;
   logic          r2_pres_ff;
   logic [SQ_W-1:0] rsq_ff;
   logic [11:0]   ref_rd, obs_rd;
   logic signed [12:0] rdiff;
   logic [12:0]   ardiff;
   logic [TOT_W-1:0] total_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic [CMP_W-1:0] num_ff;
   logic [3:0]    bit_ff;
   logic [15:0]   root_ff;
   logic [15:0]   trial;
   logic [31:0]   sq_ff;
   logic [CMP_W-1:0] prod;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

   assign pose_we = accept && (req_data.cmd == CMD_POSE)
                    && (32'(req_data.entry_index) < MAX_ENTRIES);
   assign ref_we  = accept && (req_data.cmd == CMD_REF_RSSI)
                    && (32'(req_data.entry_index) < MAX_ENTRIES)
                    && (32'(req_data.beacon_index) < NUM_BEACONS);
   assign obs_we  = accept && (req_data.cmd == CMD_OBS_RSSI)
                    && (32'(req_data.beacon_index) < NUM_BEACONS);

   assign pose_wr.x           = req_data.pos_x;
   assign pose_wr.y           = req_data.pos_y;
   assign pose_wr.orientation = req_data.orientation;

   assign scan_rd = (state_ff == ST_SCAN) && !scan_done_ff;
   assign rad_rd  = (state_ff == ST_RADIO) && !rad_done_ff;

   nfrd_ram #(.WIDTH(POSE_W), .DEPTH(2 ** EW)) u_pose_ram (
      .clock   (clock),
      .wr_en   (pose_we),
      .wr_addr (EW'(req_data.entry_index)),
      .wr_data (pose_wr),
      .rd_en   (scan_rd),
      .rd_addr (scan_ff),
      .rd_data (pose_rd_bits)
   );

   nfrd_ram #(.WIDTH(12), .DEPTH(2 ** (EW + BW))) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr ({EW'(req_data.entry_index), BW'(req_data.beacon_index)}),
      .wr_data (req_data.rssi_value),
      .rd_en   (rad_rd),
      .rd_addr ({best_ff, rb_ff}),
      .rd_data (ref_rd)
   );

   nfrd_ram #(.WIDTH(12), .DEPTH(2 ** BW)) u_obs_ram (
      .clock   (clock),
      .wr_en   (obs_we),
      .wr_addr (BW'(req_data.beacon_index)),
      .wr_data (req_data.rssi_value),
      .rd_en   (rad_rd),
      .rd_addr (rb_ff),
      .rd_data (obs_rd)
   );

   assign pose_rd = pose_rd_bits;
   assign dx      = 25'(qx_ff) - 25'(pose_rd.x);
   assign dy      = 25'(qy_ff) - 25'(pose_rd.y);
   assign adx     = dx[24] ? 25'(-dx) : 25'(dx);
   assign ady     = dy[24] ? 25'(-dy) : 25'(dy);
   assign adiff   = (pose_rd.orientation > qori_ff) ? (pose_rd.orientation - qori_ff)
                                                    : (qori_ff - pose_rd.orientation);
   assign cur_d   = DIST_W'(sqx_ff) + DIST_W'(sqy_ff);

   assign rdiff   = 13'($signed(ref_rd)) - 13'($signed(obs_rd));
   assign ardiff  = rdiff[12] ? 13'(-rdiff) : 13'(rdiff);

   assign trial   = root_ff | (16'd1 << bit_ff);
   assign prod    = CMP_W'(sq_ff) * CMP_W'(cnt_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.cmd == CMD_QUERY) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done_ff && !s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_RADIO;
            end
         end
         ST_RADIO: begin
            if (rad_done_ff && !r1_vld_ff && !r2_vld_ff) begin
               state_in = (cnt_ff == '0) ? ST_DONE : ST_PREP;
            end
         end
         ST_PREP: state_in = ST_SQ;
         ST_SQ:   state_in = ST_CMP;
         ST_CMP:  state_in = (bit_ff == 4'd0) ? ST_DONE : ST_SQ;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_DONE: rsp_valid = 1'b1;
         default: rsp_valid = 1'b0;
      endcase
   end

   assign rsp_data.radio_distance = (cnt_ff == '0) ? ALL_MISSING_DIST : root_ff;
   assign rsp_data.nearest_index  = 8'(best_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_ff       <= 9'd1;
         scan_done_ff <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rad_done_ff  <= 1'b0;
         r1_vld_ff    <= 1'b0;
         r2_vld_ff    <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         s1_vld_ff <= scan_rd;
         s2_vld_ff <= s1_vld_ff;
         r1_vld_ff <= rad_rd;
         r2_vld_ff <= r1_vld_ff;
         if (csr_valid && csr_ready) begin
            csr_ff <= csr_data;
         end
         if (accept && req_data.cmd == CMD_QUERY) begin
            scan_done_ff <= 1'b0;
            rad_done_ff  <= 1'b0;
            first_ff     <= 1'b1;
         end else begin
            if (scan_rd && scan_ff == last_ff) begin
               scan_done_ff <= 1'b1;
            end
            if (rad_rd && rb_ff == BW'(NUM_BEACONS - 1)) begin
               rad_done_ff <= 1'b1;
            end
            if (s2_vld_ff) begin
               first_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.cmd == CMD_QUERY) begin
         qx_ff    <= req_data.pos_x;
         qy_ff    <= req_data.pos_y;
         qori_ff  <= req_data.orientation;
         scan_ff  <= '0;
         rb_ff    <= '0;
         total_ff <= '0;
         cnt_ff   <= '0;
         root_ff  <= '0;
         bit_ff   <= 4'd15;
         if (csr_ff == 9'd0) begin
            last_ff <= '0;
         end else if (32'(csr_ff) > MAX_ENTRIES) begin
            last_ff <= EW'(MAX_ENTRIES - 1);
         end else begin
            last_ff <= EW'(csr_ff - 9'd1);
         end
      end else begin
         if (scan_rd && scan_ff != last_ff) begin
            scan_ff <= scan_ff + 1'b1;
         end
         if (rad_rd && rb_ff != BW'(NUM_BEACONS - 1)) begin
            rb_ff <= rb_ff + 1'b1;
         end
         if (r2_vld_ff && r2_pres_ff) begin
            total_ff <= total_ff + TOT_W'(rsq_ff);
            cnt_ff   <= cnt_ff + 1'b1;
         end
         if (state_ff == ST_CMP) begin
            if (prod <= num_ff) begin
               root_ff <= trial;
            end
            bit_ff <= bit_ff - 4'd1;
         end
      end
      s1_idx_ff  <= scan_ff;
      s2_idx_ff  <= s1_idx_ff;
      sqx_ff     <= 50'(adx) * 50'(adx);
      sqy_ff     <= 50'(ady) * 50'(ady);
      ang_ff     <= adiff;
      rsq_ff     <= SQ_W'(ardiff) * SQ_W'(ardiff);
      r2_pres_ff <= (ref_rd != 12'd0);
      if (s2_vld_ff && (first_ff || cur_d < best_d_ff
                        || (cur_d == best_d_ff && ang_ff < best_a_ff))) begin
         best_ff   <= s2_idx_ff;
         best_d_ff <= cur_d;
         best_a_ff <= ang_ff;
      end
      if (state_ff == ST_PREP) begin
         num_ff <= CMP_W'(total_ff) * CMP_W'(NUM_BEACONS);
      end
      if (state_ff == ST_SQ) begin
         sq_ff <= 32'(trial) * 32'(trial);
      end
   end

endmodule

// ----- hdl/nfrd_checker.sv -----
// Port-level checker for the nearest fingerprint RSSI distance block.
// It depends on nfrd_pkg and binds to nearest_fingerprint_rssi_distance_top.
`timescale 1ns / 1ps

module nfrd_checker
   import nfrd_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            csr_ready
);

   a_strobe_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle or busy held after it");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.cmd == CMD_QUERY |=> busy && !rsp_valid)
      else $error("query beat did not raise busy");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.cmd != CMD_QUERY |=> !busy && !rsp_valid)
      else $error("write beat caused busy or a result");

   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat shown while idle");

   a_csr_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> csr_ready)
      else $error("csr channel not ready while idle");

endmodule

bind nearest_fingerprint_rssi_distance_top nfrd_checker u_nfrd_checker (.*);
